[sv/mbr_pkg.sv]
// ----------------------------------------------------------------------------
// mbr_pkg
// shared types, request codes and helpers for the msb-first bitstream reader
// ----------------------------------------------------------------------------
package mbr_pkg;

    // default sizes
    localparam int BUF_BYTES_DEF    = 4096;
    localparam int MAX_BYTE_RUN_DEF = 64;
    localparam int QUEUE_DEPTH      = 2;

    // fixed field widths
    localparam int ADDR_MAX_W = 16;   // widest store address over the allowed sizes
    localparam int RUN_W      = 7;    // byte run count, up to 64
    localparam int OFF_W      = 13;   // byte_offset result field

    // request codes
    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_GET     = 3'd1;
    localparam logic [2:0] REQ_PEEK    = 3'd2;
    localparam logic [2:0] REQ_DROP    = 3'd3;
    localparam logic [2:0] REQ_BYTES   = 3'd4;
    localparam logic [2:0] REQ_SHORT   = 3'd5;
    localparam logic [2:0] REQ_ALIGN   = 3'd6;
    localparam logic [2:0] REQ_RESTART = 3'd7;

    // work kinds handed to the back end
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_BITS  = 2'd1;
    localparam logic [1:0] K_SHORT = 2'd2;
    localparam logic [1:0] K_RUN   = 2'd3;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] load_data;
        logic [7:0] amount;
    } cmd_t;

    typedef struct packed {
        logic [15:0]      value;
        logic             ok;
        logic             last;
        logic [OFF_W-1:0] byte_offset;
        logic [2:0]       bit_offset;
    } rsp_t;

    // classified request waiting for the back end
    typedef struct packed {
        logic [1:0]            kind;
        logic                  ok;
        logic [ADDR_MAX_W-1:0] addr;
        logic [2:0]            bitpos;
        logic [3:0]            nbits;
        logic [RUN_W-1:0]      count;
        logic [OFF_W-1:0]      byte_offset;
        logic [2:0]            bit_offset;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // pick n bits msb first out of a two byte window starting at bitpos
    function automatic logic [15:0] extract_bits(input logic [15:0] window,
                                                 input logic [2:0]  bitpos,
                                                 input logic [3:0]  n);
        logic [4:0]  sh;
        logic [15:0] mask;
        sh   = 5'd16 - {2'b00, bitpos} - {1'b0, n};
        mask = (16'h0001 << n) - 16'h0001;
        return (window >> sh) & mask;
    endfunction

endpackage

[sv/mbr_ram.sv]
// ----------------------------------------------------------------------------
// mbr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/mbr_front.sv]
// ----------------------------------------------------------------------------
// mbr_front
// accepts requests, keeps the read position, checks bounds, appends loaded
// bytes and queues classified work; alignment uses a bit-serial remainder unit
// ----------------------------------------------------------------------------
module mbr_front #(
    parameter int BUF_BYTES    = mbr_pkg::BUF_BYTES_DEF,
    parameter int MAX_BYTE_RUN = mbr_pkg::MAX_BYTE_RUN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  mbr_pkg::cmd_t                cmd,
    output logic                         busy,
    input  logic                         q_full,
    input  logic                         drain_clear,
    output logic                         push,
    output mbr_pkg::entry_t              push_ent,
    output logic                         wr_en,
    output logic [$clog2(BUF_BYTES)-1:0] wr_addr,
    output logic [7:0]                   wr_data
);

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int CNT_W  = $clog2(BUF_BYTES + 1);
    localparam int BL_W   = CNT_W + 3;
    localparam int CW_W   = $clog2(CNT_W + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [2:0]       bit_reg, bit_next;
    logic             drain_reg, drain_next;

    logic             div_busy_reg, div_busy_next;
    logic [CW_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0] div_num_reg, div_num_next;
    logic [7:0]       div_rem_reg, div_rem_next;
    logic [CNT_W-1:0] div_p_reg, div_p_next;
    logic [7:0]       div_amt_reg, div_amt_next;

    logic             acc;
    logic [BL_W-1:0]  used;
    logic [BL_W-1:0]  total;
    logic [BL_W-1:0]  bits_left;
    logic [BL_W-1:0]  adv;
    logic [8:0]       trial;
    logic [CNT_W:0]   up;

    assign busy = q_full | div_busy_reg | drain_reg;
    assign acc  = start & ~busy;

    // bit positions
    assign used      = {pos_reg, bit_reg};
    assign total     = {count_reg, 3'b000};
    assign bits_left = total - used;
    assign adv       = used + BL_W'(cmd.amount);
    assign trial     = {div_rem_reg, div_num_reg[CNT_W-1]};

    // classification and position update
    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        bit_next      = bit_reg;
        drain_next    = drain_reg;
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        div_num_next  = div_num_reg;
        div_rem_next  = div_rem_reg;
        div_p_next    = div_p_reg;
        div_amt_next  = div_amt_reg;
        wr_en         = 1'b0;
        wr_addr       = ADDR_W'(count_reg);
        wr_data       = cmd.load_data;
        push          = 1'b0;
        up            = '0;

        push_ent.kind        = mbr_pkg::K_NONE;
        push_ent.ok          = 1'b1;
        push_ent.addr        = mbr_pkg::ADDR_MAX_W'(pos_reg);
        push_ent.bitpos      = bit_reg;
        push_ent.nbits       = cmd.amount[3:0];
        push_ent.count       = cmd.amount[mbr_pkg::RUN_W-1:0];
        push_ent.byte_offset = '0;
        push_ent.bit_offset  = '0;

        if (div_busy_reg)
        begin
            if (div_cnt_reg != '0)
            begin
                // one remainder bit per cycle
                if (trial >= {1'b0, div_amt_reg})
                begin
                    div_rem_next = 8'(trial - {1'b0, div_amt_reg});
                end
                else
                begin
                    div_rem_next = trial[7:0];
                end
                div_num_next = div_num_reg << 1;
                div_cnt_next = div_cnt_reg - CW_W'(1);
            end
            else
            begin
                // round up to the boundary and clamp to the data end
                if (div_rem_reg == 8'd0)
                begin
                    up = {1'b0, div_p_reg};
                end
                else
                begin
                    up = {1'b0, div_p_reg} + (CNT_W + 1)'(div_amt_reg)
                         - (CNT_W + 1)'(div_rem_reg);
                end
                if (up > {1'b0, count_reg})
                begin
                    up = {1'b0, count_reg};
                end
                pos_next      = up[CNT_W-1:0];
                bit_next      = 3'd0;
                div_busy_next = 1'b0;
                push          = 1'b1;
            end
        end
        else if (acc)
        begin
            push = 1'b1;
            case (cmd.req_type)
                mbr_pkg::REQ_LOAD:
                begin
                    if (count_reg < CNT_W'(BUF_BYTES))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        push_ent.ok = 1'b0;
                    end
                end
                mbr_pkg::REQ_GET, mbr_pkg::REQ_PEEK:
                begin
                    if (cmd.amount > 8'd8 || bits_left < BL_W'(cmd.amount))
                    begin
                        push_ent.ok = 1'b0;
                    end
                    else
                    begin
                        if (cmd.amount != 8'd0)
                        begin
                            push_ent.kind = mbr_pkg::K_BITS;
                        end
                        if (cmd.req_type == mbr_pkg::REQ_GET)
                        begin
                            pos_next = adv[BL_W-1:3];
                            bit_next = adv[2:0];
                        end
                    end
                end
                mbr_pkg::REQ_DROP:
                begin
                    if (bits_left < BL_W'(cmd.amount))
                    begin
                        push_ent.ok = 1'b0;
                    end
                    else
                    begin
                        pos_next = adv[BL_W-1:3];
                        bit_next = adv[2:0];
                    end
                end
                mbr_pkg::REQ_BYTES:
                begin
                    if (cmd.amount > 8'(MAX_BYTE_RUN) || bit_reg != 3'd0
                        || bits_left < BL_W'({cmd.amount, 3'b000}))
                    begin
                        push_ent.ok = 1'b0;
                    end
                    else if (cmd.amount != 8'd0)
                    begin
                        push_ent.kind = mbr_pkg::K_RUN;
                        pos_next      = pos_reg + CNT_W'(cmd.amount);
                    end
                end
                mbr_pkg::REQ_SHORT:
                begin
                    if (bit_reg != 3'd0 || bits_left < BL_W'(16))
                    begin
                        push_ent.ok = 1'b0;
                    end
                    else
                    begin
                        push_ent.kind = mbr_pkg::K_SHORT;
                        pos_next      = pos_reg + CNT_W'(2);
                    end
                end
                mbr_pkg::REQ_ALIGN:
                begin
                    if (cmd.amount != 8'd0)
                    begin
                        // result is queued once the remainder is known
                        push          = 1'b0;
                        div_busy_next = 1'b1;
                        div_cnt_next  = CW_W'(CNT_W);
                        div_rem_next  = 8'd0;
                        div_amt_next  = cmd.amount;
                        div_p_next    = pos_reg + CNT_W'(bit_reg != 3'd0);
                        div_num_next  = pos_reg + CNT_W'(bit_reg != 3'd0);
                    end
                end
                default:
                begin
                    // restart
                    count_next = '0;
                    pos_next   = '0;
                    bit_next   = 3'd0;
                end
            endcase
        end

        push_ent.byte_offset = mbr_pkg::OFF_W'(pos_next);
        push_ent.bit_offset  = bit_next;

        // after a restart wait until older reads are done before taking new requests
        if (acc && cmd.req_type == mbr_pkg::REQ_RESTART)
        begin
            drain_next = 1'b1;
        end
        else if (drain_reg && drain_clear)
        begin
            drain_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pos_reg      <= '0;
            bit_reg      <= 3'd0;
            drain_reg    <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            bit_reg      <= bit_next;
            drain_reg    <= drain_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_p_reg   <= div_p_next;
        div_amt_reg <= div_amt_next;
    end

    // read position never passes the loaded data
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used <= total)
        else $error("read position beyond loaded data");

    // no work is queued into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

endmodule

[sv/mbr_queue.sv]
// ----------------------------------------------------------------------------
// mbr_queue
// short fifo of classified requests between front and back end
// ----------------------------------------------------------------------------
module mbr_queue #(
    parameter int DEPTH = mbr_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mbr_pkg::entry_t    push_ent,
    input  logic               pop,
    output mbr_pkg::entry_t    head,
    output mbr_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbr_pkg::entry_t  slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign head         = slots_reg[rd_ptr_reg];

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

[sv/mbr_back.sv]
// ----------------------------------------------------------------------------
// mbr_back
// carries out queued work: reads the byte store and sends one result word
// per cycle at most
// ----------------------------------------------------------------------------
module mbr_back #(
    parameter int BUF_BYTES = mbr_pkg::BUF_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mbr_pkg::entry_t              head,
    input  mbr_pkg::q_status_t           q_status,
    output logic                         pop,
    output logic                         idle,
    output logic                         rd_en,
    output logic [$clog2(BUF_BYTES)-1:0] rd_addr,
    input  logic [7:0]                   rd_data,
    output logic                         rsp_valid,
    output mbr_pkg::rsp_t                rsp
);

    localparam int ADDR_W = $clog2(BUF_BYTES);

    localparam logic [1:0] B_IDLE   = 2'd0;
    localparam logic [1:0] B_FIRST  = 2'd1;
    localparam logic [1:0] B_SECOND = 2'd2;
    localparam logic [1:0] B_RUN    = 2'd3;

    logic [1:0]                state_reg, state_next;
    mbr_pkg::entry_t           ent_reg, ent_next;
    logic [7:0]                b0_reg, b0_next;
    logic [mbr_pkg::RUN_W-1:0] idx_reg, idx_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    mbr_pkg::rsp_t             rsp_reg, rsp_next;
    logic                      need2;
    logic [15:0]               window;

    assign idle      = (state_reg == B_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // second byte needed when the bit field crosses into it
    assign need2 = ({1'b0, ent_reg.bitpos} + ent_reg.nbits) > 4'd8;

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        b0_next        = b0_reg;
        idx_next       = idx_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = ADDR_W'(head.addr);
        window         = {b0_reg, rd_data};

        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    ent_next = head;
                    if (head.kind == mbr_pkg::K_NONE)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.value       = 16'd0;
                        rsp_next.ok          = head.ok;
                        rsp_next.last        = 1'b1;
                        rsp_next.byte_offset = head.byte_offset;
                        rsp_next.bit_offset  = head.bit_offset;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = mbr_pkg::RUN_W'(1);
                        state_next = (head.kind == mbr_pkg::K_RUN) ? B_RUN : B_FIRST;
                    end
                end
            end
            B_FIRST:
            begin
                rsp_next.ok          = 1'b1;
                rsp_next.last        = 1'b1;
                rsp_next.byte_offset = ent_reg.byte_offset;
                rsp_next.bit_offset  = ent_reg.bit_offset;
                if (ent_reg.kind == mbr_pkg::K_SHORT || need2)
                begin
                    b0_next    = rd_data;
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(ent_reg.addr + mbr_pkg::ADDR_MAX_W'(1));
                    state_next = B_SECOND;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.value = mbr_pkg::extract_bits({rd_data, 8'h00},
                                                           ent_reg.bitpos, ent_reg.nbits);
                    state_next     = B_IDLE;
                end
            end
            B_SECOND:
            begin
                rsp_valid_next = 1'b1;
                if (ent_reg.kind == mbr_pkg::K_SHORT)
                begin
                    rsp_next.value = window;
                end
                else
                begin
                    rsp_next.value = mbr_pkg::extract_bits(window, ent_reg.bitpos,
                                                           ent_reg.nbits);
                end
                state_next = B_IDLE;
            end
            default:
            begin
                // byte run: one byte word per cycle, next read issued alongside
                rsp_valid_next       = 1'b1;
                rsp_next.value       = {8'h00, rd_data};
                rsp_next.ok          = 1'b1;
                rsp_next.last        = (idx_reg == ent_reg.count);
                rsp_next.byte_offset = ent_reg.byte_offset;
                rsp_next.bit_offset  = ent_reg.bit_offset;
                if (idx_reg == ent_reg.count)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ADDR_W'(ent_reg.addr + mbr_pkg::ADDR_MAX_W'(idx_reg));
                    idx_next = idx_reg + mbr_pkg::RUN_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        b0_reg  <= b0_next;
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
    end

    // the second byte is only fetched right after the first
    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_SECOND |-> $past(state_reg) == B_FIRST)
        else $error("second byte step without first byte step");

    // the words of a byte run come on consecutive cycles
    a_run_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.last |=> rsp_valid_reg)
        else $error("gap inside a byte run");

endmodule

[sv/msb_first_bitstream_reader_core.sv]
// ----------------------------------------------------------------------------
// msb_first_bitstream_reader_core
// msb-first bit reader over a loaded byte buffer, front end classifies and
// tracks the position, back end reads the store and sends result words
// ----------------------------------------------------------------------------
//  channel   | handshake              | word
//  ----------+------------------------+-------------------------------------
//  request   | start / busy           | cmd  (req_type, load_data, amount)
//  result    | rsp_valid, one cycle   | rsp  (value, ok, last, offsets)
//
//  front end takes one request per cycle while the two-entry queue has room;
//  align with a nonzero amount holds it while the bit-serial remainder unit runs
//  back end per request: no store read when no data is needed, one read for a
//  bit field in one byte, two for a short or a field spanning two bytes, one
//  per byte for a byte run, all through the registered single store read port
//  after a restart the next request waits until queued work has drained
//  reset clears positions and byte count, the store itself is not cleared;
//  results cannot be held off, each is shown for exactly one cycle
// ----------------------------------------------------------------------------
module msb_first_bitstream_reader_core #(
    parameter int BUF_BYTES    = mbr_pkg::BUF_BYTES_DEF,
    parameter int MAX_BYTE_RUN = mbr_pkg::MAX_BYTE_RUN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mbr_pkg::cmd_t cmd,
    output logic          rsp_valid,
    output mbr_pkg::rsp_t rsp
);

    localparam int ADDR_W = $clog2(BUF_BYTES);

    logic               push;
    mbr_pkg::entry_t    push_ent;
    logic               pop;
    mbr_pkg::entry_t    head;
    mbr_pkg::q_status_t q_status;
    logic               back_idle;
    logic               drain_clear;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;

    assign drain_clear = q_status.empty & back_idle;

    // request side
    mbr_front #(
        .BUF_BYTES    (BUF_BYTES),
        .MAX_BYTE_RUN (MAX_BYTE_RUN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .q_full      (q_status.full),
        .drain_clear (drain_clear),
        .push        (push),
        .push_ent    (push_ent),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    // work queue
    mbr_queue #(
        .DEPTH (mbr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // byte store
    mbr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result side
    mbr_back #(
        .BUF_BYTES (BUF_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .idle      (back_idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

[verif/msb_first_bitstream_reader_checker.sv]
// ----------------------------------------------------------------------------
// msb_first_bitstream_reader_checker
// watches the request and result channels of the bitstream reader, keeps a
// shadow of the byte store and read position, and checks every result word
// against the words owed by the requests accepted so far
// ----------------------------------------------------------------------------
module msb_first_bitstream_reader_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  mbr_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  mbr_pkg::rsp_t rsp,
    output int            errors,
    output int            pending,
    output int            checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_BYTES = mbr_pkg::BUF_BYTES_DEF;
    localparam int unsigned RUN_MAX     = mbr_pkg::MAX_BYTE_RUN_DEF;

    // shadow of the reader state
    logic [7:0]  shadow_store [STORE_BYTES];
    int unsigned fill_count;
    int unsigned rd_byte;
    int unsigned rd_bit;

    // result words still owed by accepted requests, oldest first
    mbr_pkg::rsp_t owed_words [$];
    int            mismatches = 0;
    int            words_seen = 0;

    assign errors  = mismatches;
    assign checked = words_seen;

    // one bit of loaded data at absolute bit position p, msb first
    function automatic int unsigned bit_at(int unsigned p);
        int unsigned idx;
        idx = p >> 3;
        if (idx >= fill_count)
            return 0;
        return (shadow_store[idx] >> (7 - (p & 7))) & 1;
    endfunction

    // n bits starting at absolute bit position p, right justified
    function automatic logic [15:0] fetch_bits(int unsigned p, int unsigned n);
        logic [15:0] v;
        v = '0;
        for (int unsigned i = 0; i < n; i++)
            v = (v << 1) | 16'(bit_at(p + i));
        return v;
    endfunction

    function automatic void move_to(int unsigned p);
        rd_byte = p >> 3;
        rd_bit  = p & 7;
    endfunction

    // queue one owed word, offsets taken after the whole request
    function automatic void owe(logic [15:0] value, logic ok, logic last);
        mbr_pkg::rsp_t w;
        w.value       = value;
        w.ok          = ok;
        w.last        = last;
        w.byte_offset = rd_byte[mbr_pkg::OFF_W-1:0];
        w.bit_offset  = rd_bit[2:0];
        owed_words.push_back(w);
    endfunction

    // apply one accepted request to the shadow state and owe its words
    function automatic void advance_reader(mbr_pkg::cmd_t c);
        int unsigned pos;
        int unsigned avail;
        int unsigned amt;
        int unsigned first;
        int unsigned p;
        logic [15:0] value;
        logic        ok;
        pos   = rd_byte * 8 + rd_bit;
        avail = (fill_count * 8 >= pos) ? fill_count * 8 - pos : 0;
        amt   = c.amount;
        value = '0;
        ok    = 1'b1;
        case (c.req_type)
            mbr_pkg::REQ_LOAD:
            begin
                if (fill_count < STORE_BYTES)
                begin
                    shadow_store[fill_count] = c.load_data;
                    fill_count++;
                end
                else
                    ok = 1'b0;
            end
            mbr_pkg::REQ_GET, mbr_pkg::REQ_PEEK:
            begin
                if (amt > 8 || avail < amt)
                    ok = 1'b0;
                else
                begin
                    value = fetch_bits(pos, amt);
                    if (c.req_type == mbr_pkg::REQ_GET)
                        move_to(pos + amt);
                end
            end
            mbr_pkg::REQ_DROP:
            begin
                if (avail < amt)
                    ok = 1'b0;
                else
                    move_to(pos + amt);
            end
            mbr_pkg::REQ_BYTES:
            begin
                if (amt > RUN_MAX || rd_bit != 0 || avail < amt * 8)
                    ok = 1'b0;
                else if (amt > 0)
                begin
                    first   = rd_byte;
                    rd_byte = first + amt;
                    for (int unsigned i = 0; i < amt; i++)
                        owe(16'(shadow_store[first + i]), 1'b1, i + 1 == amt);
                    return;
                end
            end
            mbr_pkg::REQ_SHORT:
            begin
                if (rd_bit != 0 || avail < 16)
                    ok = 1'b0;
                else
                begin
                    value   = fetch_bits(pos, 16);
                    rd_byte = rd_byte + 2;
                end
            end
            mbr_pkg::REQ_ALIGN:
            begin
                if (amt != 0)
                begin
                    p = rd_byte;
                    // finish the partial byte first, then round up and clamp
                    if (rd_bit != 0)
                    begin
                        p++;
                        rd_bit = 0;
                    end
                    if (p % amt != 0)
                        p = ((p + amt - 1) / amt) * amt;
                    if (p > fill_count)
                        p = fill_count;
                    rd_byte = p;
                end
            end
            default:
            begin
                fill_count = 0;
                rd_byte    = 0;
                rd_bit     = 0;
            end
        endcase
        owe(ok ? value : 16'h0000, ok, 1'b1);
    endfunction

    function automatic void compare_word(mbr_pkg::rsp_t got, mbr_pkg::rsp_t want);
        if (got.value !== want.value)
        begin
            $error("value: expected %0h, got %0h", want.value, got.value);
            mismatches++;
        end
        if (got.ok !== want.ok)
        begin
            $error("ok: expected %0b, got %0b", want.ok, got.ok);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
        end
        if (got.byte_offset !== want.byte_offset)
        begin
            $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
            mismatches++;
        end
        if (got.bit_offset !== want.bit_offset)
        begin
            $error("bit_offset: expected %0d, got %0d", want.bit_offset, got.bit_offset);
            mismatches++;
        end
    endfunction

    // results are checked before the request taken on the same edge is applied
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count = 0;
            rd_byte    = 0;
            rd_bit     = 0;
            owed_words.delete();
        end
        else
        begin
            if (rsp_valid)
            begin
                words_seen++;
                if (owed_words.size() == 0)
                begin
                    $error("result word with no request outstanding: value %0h", rsp.value);
                    mismatches++;
                end
                else
                    compare_word(rsp, owed_words.pop_front());
            end
            if (start && !busy)
                advance_reader(cmd);
        end
        pending = owed_words.size();
    end

endmodule

[verif/msb_first_bitstream_reader_core_tb.sv]
// ----------------------------------------------------------------------------
// msb_first_bitstream_reader_core_tb
// drives directed and random request words into the bitstream reader with
// varying sender gaps and lets the checker beside the block compare every
// result word
// ----------------------------------------------------------------------------
module msb_first_bitstream_reader_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 200;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    mbr_pkg::cmd_t cmd;
    logic          rsp_valid;
    mbr_pkg::rsp_t rsp;

    int errors;
    int pending;
    int checked;
    int cycles = 0;
    int send_idle_pct = 0;
    int request_tally [8];

    msb_first_bitstream_reader_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    msb_first_bitstream_reader_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // random sender gap after an accepted word
    task automatic sender_gap();
        int n;
        n = 0;
        while (n < 40 && $urandom_range(0, 99) < send_idle_pct)
            n++;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // present one request word and hold it until the block takes it
    task automatic issue(logic [2:0] kind, logic [7:0] data, logic [7:0] amt);
        mbr_pkg::cmd_t c;
        bit            taken;
        c.req_type  = kind;
        c.load_data = data;
        c.amount    = amt;
        start <= 1'b1;
        cmd   <= c;
        request_tally[kind]++;
        taken = 1'b0;
        // busy is stable mid-cycle, so the next edge takes the word
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
        end
        @(posedge clk);
        sender_gap();
    endtask

    function automatic logic [7:0] bit_amount();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    endfunction

    // mostly well-formed traffic: loads feeding reads, with some noise amounts
    task automatic random_request();
        int          r;
        int          sel;
        logic [7:0]  amt;
        r = $urandom_range(0, 99);
        if (r < 35)
            issue(mbr_pkg::REQ_LOAD, 8'($urandom), 8'($urandom));
        else if (r < 47)
            issue(mbr_pkg::REQ_GET, 8'($urandom), bit_amount());
        else if (r < 55)
            issue(mbr_pkg::REQ_PEEK, 8'($urandom), bit_amount());
        else if (r < 63)
        begin
            amt = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
            issue(mbr_pkg::REQ_DROP, 8'($urandom), amt);
        end
        else if (r < 84)
        begin
            // byte aligned reads come right after an align to one byte half of the time
            if ($urandom_range(0, 1))
                issue(mbr_pkg::REQ_ALIGN, 8'($urandom), 8'd1);
            if (r < 75)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    amt = 8'($urandom);
                else if (sel == 1)
                    amt = 8'($urandom_range(56, 66));
                else
                    amt = 8'($urandom_range(0, 6));
                issue(mbr_pkg::REQ_BYTES, 8'($urandom), amt);
            end
            else
                issue(mbr_pkg::REQ_SHORT, 8'($urandom), 8'($urandom));
        end
        else if (r < 97)
        begin
            amt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
            issue(mbr_pkg::REQ_ALIGN, 8'($urandom), amt);
        end
        else
            issue(mbr_pkg::REQ_RESTART, 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty buffer, edge amounts, unaligned refusals
        issue(mbr_pkg::REQ_GET, 8'h00, 8'd0);
        issue(mbr_pkg::REQ_GET, 8'h00, 8'd1);
        issue(mbr_pkg::REQ_SHORT, 8'h00, 8'd0);
        issue(mbr_pkg::REQ_BYTES, 8'h00, 8'd0);
        issue(mbr_pkg::REQ_LOAD, 8'h00, 8'hff);
        issue(mbr_pkg::REQ_LOAD, 8'hff, 8'h00);
        issue(mbr_pkg::REQ_LOAD, 8'ha5, 8'h00);
        issue(mbr_pkg::REQ_LOAD, 8'h3c, 8'h00);
        issue(mbr_pkg::REQ_LOAD, 8'h81, 8'h00);
        issue(mbr_pkg::REQ_LOAD, 8'h7e, 8'h00);
        issue(mbr_pkg::REQ_PEEK, 8'h00, 8'd8);
        issue(mbr_pkg::REQ_GET, 8'h00, 8'd9);
        issue(mbr_pkg::REQ_PEEK, 8'hff, 8'd0);
        issue(mbr_pkg::REQ_DROP, 8'h00, 8'd3);
        issue(mbr_pkg::REQ_ALIGN, 8'h00, 8'd0);
        issue(mbr_pkg::REQ_SHORT, 8'h00, 8'd0);
        issue(mbr_pkg::REQ_BYTES, 8'h00, 8'd1);
        issue(mbr_pkg::REQ_ALIGN, 8'h00, 8'd1);
        issue(mbr_pkg::REQ_GET, 8'h00, 8'd8);
        issue(mbr_pkg::REQ_SHORT, 8'h00, 8'd0);
        issue(mbr_pkg::REQ_BYTES, 8'h00, 8'd65);
        issue(mbr_pkg::REQ_BYTES, 8'h00, 8'd2);
        issue(mbr_pkg::REQ_DROP, 8'h00, 8'd255);
        issue(mbr_pkg::REQ_RESTART, 8'hff, 8'hff);

        // random traffic over three sender idling profiles
        send_idle_pct = 34;
        repeat (95) random_request();
        send_idle_pct = 69;
        repeat (95) random_request();
        send_idle_pct = 0;
        repeat (85) random_request();

        // restart and read freshly loaded data
        issue(mbr_pkg::REQ_RESTART, 8'h00, 8'h00);
        issue(mbr_pkg::REQ_LOAD, 8'h5a, 8'h00);
        issue(mbr_pkg::REQ_GET, 8'h00, 8'd8);
        start <= 1'b0;

        // let the last words come out
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d loads, %0d gets, %0d peeks, %0d drops, %0d byte runs,",
                 request_tally[mbr_pkg::REQ_LOAD], request_tally[mbr_pkg::REQ_GET],
                 request_tally[mbr_pkg::REQ_PEEK], request_tally[mbr_pkg::REQ_DROP],
                 request_tally[mbr_pkg::REQ_BYTES]);
        $display("%0d shorts, %0d aligns, %0d restarts; %0d words checked",
                 request_tally[mbr_pkg::REQ_SHORT], request_tally[mbr_pkg::REQ_ALIGN],
                 request_tally[mbr_pkg::REQ_RESTART], checked);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
